>>> rtl/lkv_pkg.sv
// lkv_pkg: shared types and constants of the lru key/value cache
`timescale 1ns / 1ps
`default_nettype none

package lkv_pkg;

    localparam int CAPACITY = 8;
    localparam int KEY_BITS = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int VAL_W    = 64;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;
    localparam logic KIND_INT   = 1'b0;
    localparam logic KIND_DBL   = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [63:0]       lookup_key;
        logic              kind_tag;
        logic [63:0]       write_value;
    } lkv_req_t;

    typedef struct packed {
        logic              hit;
        logic [63:0]       read_value;
    } lkv_rsp_t;

    // tag store answer for the request on the port
    typedef struct packed {
        logic              hit;
        logic [IDX_W-1:0]  slot;
    } lkv_sel_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RESP = 2'b10
    } lkv_state_t;

endpackage

`default_nettype wire

>>> rtl/lkv_ram.sv
// lkv_ram: generic single-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module lkv_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic             re,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/lkv_tag.sv
// lkv_tag: key/kind/valid/recency register store with parallel compare
`timescale 1ns / 1ps
`default_nettype none

module lkv_tag (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             acc,
    input  wire lkv_pkg::lkv_req_t req,
    output lkv_pkg::lkv_sel_t     sel
);
    import lkv_pkg::*;

    logic                valid_reg [CAPACITY];
    logic [KEY_BITS-1:0] key_reg   [CAPACITY];
    logic                kind_reg  [CAPACITY];
    logic [IDX_W-1:0]    rank_reg  [CAPACITY];

    logic [KEY_BITS-1:0] req_key;
    logic [CAPACITY-1:0] match;
    logic [CAPACITY-1:0] best;
    logic [CAPACITY-1:0] valid_vec;
    logic                any_hit;
    logic [IDX_W-1:0]    hit_slot;
    logic [IDX_W-1:0]    hit_rank;
    logic                full;
    logic [IDX_W-1:0]    free_slot;
    logic [IDX_W-1:0]    victim_slot;
    logic [IDX_W-1:0]    ins_slot;
    logic                is_lookup;

    assign req_key   = req.lookup_key[KEY_BITS-1:0];
    assign is_lookup = (req.req_type == REQ_LOOKUP);

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            valid_vec[i] = valid_reg[i];
            match[i] = valid_reg[i] && (key_reg[i] == req_key) &&
                       (kind_reg[i] == req.kind_tag);
        end
    end

    // most recent match: no other match holds a smaller rank
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            best[i] = match[i];
            for (int j = 0; j < CAPACITY; j++)
            begin
                if (j != i && match[j] && (rank_reg[j] < rank_reg[i]))
                begin
                    best[i] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        any_hit  = |match;
        hit_slot = '0;
        hit_rank = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (best[i])
            begin
                hit_slot = hit_slot | IDX_W'(i);
                hit_rank = hit_rank | rank_reg[i];
            end
        end
    end

    always_comb
    begin
        full        = &valid_vec;
        free_slot   = '0;
        victim_slot = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_slot = IDX_W'(i);
            end
        end
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (rank_reg[i] == IDX_W'(CAPACITY - 1)))
            begin
                victim_slot = IDX_W'(i);
            end
        end
        ins_slot = full ? victim_slot : free_slot;
    end

    assign sel.hit  = is_lookup && any_hit;
    assign sel.slot = is_lookup ? hit_slot : ins_slot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                valid_reg[i] <= 1'b0;
                rank_reg[i]  <= '0;
            end
        end
        else if (acc)
        begin
            if (is_lookup)
            begin
                if (any_hit)
                begin
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        if (best[i])
                        begin
                            rank_reg[i] <= '0;
                        end
                        else if (valid_reg[i] && (rank_reg[i] < hit_rank))
                        begin
                            rank_reg[i] <= rank_reg[i] + 1'b1;
                        end
                    end
                end
            end
            else
            begin
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if (IDX_W'(i) == ins_slot)
                    begin
                        valid_reg[i] <= 1'b1;
                        rank_reg[i]  <= '0;
                    end
                    else if (valid_reg[i])
                    begin
                        rank_reg[i] <= rank_reg[i] + 1'b1;
                    end
                end
            end
        end
    end

    // key and kind carry no reset; only read behind valid
    always_ff @(posedge clk)
    begin
        if (acc && !is_lookup)
        begin
            key_reg[ins_slot]  <= req_key;
            kind_reg[ins_slot] <= req.kind_tag;
        end
    end

`ifndef SYNTHESIS
    a_count_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> $countones(valid_vec) >= $past($countones(valid_vec)))
        else $error("valid entry lost");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && !is_lookup && !full)
        |=> $countones(valid_vec) == $past($countones(valid_vec)) + 1)
        else $error("insert into free slot did not add an entry");
`endif

endmodule

`default_nettype wire

>>> rtl/lru_key_value_cache.sv
// lru_key_value_cache: top level, request control, value ram and response register
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------
//  req     | req_valid, req_stall | req (type, key, kind, value)
//  rsp     | rsp_valid, rsp_stall | rsp (hit, read_value)
//
// each request: compare and tag/rank update plus value ram access in the accept
// cycle, then the ram read data loads the response register in ST_RESP.
// rsp register frees the request side: a waiting response only holds ST_RESP
// until it is taken.
// reset clears the valid bits and ranks at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module lru_key_value_cache (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire lkv_pkg::lkv_req_t req,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output lkv_pkg::lkv_rsp_t      rsp
);
    import lkv_pkg::*;

    lkv_state_t       state_reg, state_next;
    logic             pend_hit_reg, pend_hit_next;
    logic             rsp_valid_reg, rsp_valid_next;
    lkv_rsp_t         rsp_reg, rsp_next;
    lkv_sel_t         sel;
    logic             acc;
    logic             load;
    logic             ram_we;
    logic             ram_re;
    logic [VAL_W-1:0] ram_wdata;
    logic [VAL_W-1:0] ram_rdata;

    assign req_stall = (state_reg != ST_IDLE);
    assign acc       = req_valid && !req_stall;
    assign load      = (state_reg == ST_RESP) && (!rsp_valid_reg || !rsp_stall);

    lkv_tag u_tag (
        .clk   (clk),
        .rst_n (rst_n),
        .acc   (acc),
        .req   (req),
        .sel   (sel)
    );

    assign ram_we    = acc && (req.req_type == REQ_INSERT);
    assign ram_re    = acc && sel.hit;
    assign ram_wdata = (req.kind_tag == KIND_INT) ? {32'd0, req.write_value[31:0]}
                                                  : req.write_value;

    lkv_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_val_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (sel.slot),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        pend_hit_next  = pend_hit_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    pend_hit_next = sel.hit;
                    state_next    = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (load)
                begin
                    rsp_next.hit        = pend_hit_reg;
                    rsp_next.read_value = pend_hit_reg ? ram_rdata : '0;
                    rsp_valid_next      = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            pend_hit_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            pend_hit_reg  <= pend_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_rsp_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg == ST_RESP))
        else $error("response raised outside the response cycle");

    a_read_then_resp: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |=> (state_reg == ST_RESP) && pend_hit_reg)
        else $error("value read without pending hit");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.hit) |-> (rsp.read_value == '0))
        else $error("miss response carries a value");
`endif

endmodule

`default_nettype wire
